FILE: rtl/lrn_pkg.sv
// package for the largest remainder normalizer
// shared widths and defaults, no dependencies
`default_nettype none
package lrn_pkg;
  localparam int unsigned MaxEntriesDef  = 16;
  localparam int unsigned TargetTotalDef = 100;
  localparam int unsigned CountW = 16;
  localparam int unsigned ShareW = 7;
  localparam int unsigned IdxW   = 4;
endpackage
`default_nettype wire

FILE: rtl/lrn_if.sv
// valid/ready channel interfaces for input and result words
// depends on lrn_pkg
`default_nettype none
interface lrn_in_if;
  logic valid;
  logic ready;
  logic signed [lrn_pkg::CountW-1:0] count_value;
  logic is_last;
  modport source (output valid, count_value, is_last, input ready);
  modport sink (input valid, count_value, is_last, output ready);
endinterface

interface lrn_out_if;
  logic valid;
  logic ready;
  logic [lrn_pkg::ShareW-1:0] share;
  logic [lrn_pkg::IdxW-1:0] entry_index;
  logic last_share;
  modport source (output valid, share, entry_index, last_share, input ready);
  modport sink (input valid, share, entry_index, last_share, output ready);
endinterface
`default_nettype wire

FILE: rtl/lrn_ram.sv
// generic single-port-write, one-read ram with registered read
// no dependencies
`default_nettype none
module lrn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(Depth)-1:0]  waddr_i,
  input  wire [Width-1:0]          wdata_i,
  input  wire [$clog2(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/largest_remainder_normalizer.sv
// largest remainder normalizer top, built on lrn_pkg, lrn_if and lrn_ram
// counts load at one word per cycle; after the last word each entry is read,
// divided bit by bit (no divide when the sum is zero) and written back; each
// unit moved takes a ranking scan of all entries; the fallback and fix-up passes
// walk the entries at most once each; one run at a time, input held off until
// the run ends; results wait on the sink; reset clears count, sum, sequencer, not rams
`default_nettype none
module largest_remainder_normalizer #(
  parameter int unsigned MaxEntries  = lrn_pkg::MaxEntriesDef,
  parameter int unsigned TargetTotal = lrn_pkg::TargetTotalDef
) (
  input  wire clk_i,
  input  wire rst_ni,
  lrn_in_if.sink    in_i,
  lrn_out_if.source out_o
);
  localparam int unsigned AW   = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned NW   = $clog2(MaxEntries + 1);
  localparam int unsigned TW   = $clog2(TargetTotal + 1);
  localparam int unsigned SumW = 15 + NW;
  localparam int unsigned NumW = 15 + TW + 1;
  localparam int unsigned QW   = TW + 1;
  localparam int unsigned RW   = NumW + 2;
  localparam int unsigned SW   = TW + 1;
  localparam int unsigned DW   = TW + NW + 3;
  localparam int unsigned BW   = $clog2(NumW + 2);
  localparam int unsigned ShareWd = lrn_pkg::ShareW;

  typedef enum logic [3:0] {
    LOAD, DRD, DWAIT, DIV, DWR, SUMC, SCAN_RD, SCAN, APPLY_RD, APPLY,
    FALL_RD, FALL, FIX_RD, FIX, EMIT_RD, EMIT
  } state_e;

  state_e state_q;
  logic [NW-1:0] n_q;
  logic [SumW-1:0] sum_q;
  logic [AW-1:0] idx_q, best_q;
  logic          any_q;
  logic signed [RW-1:0] bestr_q;
  logic [BW-1:0] bit_q;
  logic [NumW+1:0] rem_q;
  logic [QW-1:0] quo_q;
  logic [NumW-1:0] num_q;
  logic signed [DW-1:0] diff_q;
  logic [NW:0] k_q;
  logic [MaxEntries-1:0] used_q;
  logic obusy_q;
  logic [ShareWd-1:0] oshare_q;
  logic [lrn_pkg::IdxW-1:0] oidx_q;
  logic olast_q;

  // ram ports
  logic c_we, s_we, r_we;
  logic [AW-1:0] c_wa, s_wa, r_wa, raddr;
  logic [14:0] c_wd, c_rd;
  logic [SW-1:0] s_wd, s_rd;
  logic signed [RW-1:0] r_wd, r_rd;

  lrn_ram #(.Width(15), .Depth(MaxEntries)) u_cnt (.clk_i, .we_i(c_we), .waddr_i(c_wa),
    .wdata_i(c_wd), .raddr_i(raddr), .rdata_o(c_rd));
  lrn_ram #(.Width(SW), .Depth(MaxEntries)) u_shr (.clk_i, .we_i(s_we), .waddr_i(s_wa),
    .wdata_i(s_wd), .raddr_i(raddr), .rdata_o(s_rd));
  lrn_ram #(.Width(RW), .Depth(MaxEntries)) u_rem (.clk_i, .we_i(r_we), .waddr_i(r_wa),
    .wdata_i(r_wd), .raddr_i(raddr), .rdata_o(r_rd));

  logic [14:0] cin;
  assign cin = in_i.count_value[15] ? 15'd0 : in_i.count_value[14:0];
  assign in_i.ready = (state_q == LOAD);
  assign out_o.valid = obusy_q;
  assign out_o.share = oshare_q;
  assign out_o.entry_index = oidx_q;
  assign out_o.last_share = olast_q;

  logic acc, last_idx;
  assign acc = in_i.valid && in_i.ready;
  assign last_idx = ({{(NW-AW){1'b0}}, idx_q} == n_q - NW'(1));

  // restoring divider step: (2num+sum)/(2sum)
  logic [NumW+1:0] twos, trial, dvd;
  assign twos = {{(NumW+2-SumW-1){1'b0}}, sum_q, 1'b0};
  assign dvd = {1'b0, num_q, 1'b0} + (NumW+2)'(sum_q);
  assign trial = {rem_q[NumW:0], dvd[bit_q]};

  logic signed [RW-1:0] rcur;
  assign rcur = r_rd;
  logic better;
  always_comb begin
    if (diff_q > 0) better = !any_q || (rcur >= bestr_q);
    else            better = !any_q || (rcur < bestr_q);
  end

  // write port and read address selection
  always_comb begin
    c_we = acc && (n_q < NW'(MaxEntries));
    c_wa = n_q[AW-1:0];
    c_wd = cin;
    s_we = 1'b0; s_wa = idx_q; s_wd = '0;
    r_we = 1'b0; r_wa = idx_q; r_wd = '0;
    raddr = idx_q;
    case (state_q)
      DWR: begin
        s_we = 1'b1;
        r_we = 1'b1;
        if (sum_q == '0) s_wd = (idx_q == '0) ? SW'(TargetTotal) : '0;
        else s_wd = SW'(quo_q);
        r_wd = RW'($signed({2'b0, num_q})) - RW'($signed({1'b0, quo_q}) * $signed({1'b0, sum_q}));
      end
      APPLY: begin
        s_we = 1'b1;
        s_wa = best_q;
        raddr = best_q;
        s_wd = (diff_q > 0) ? s_rd + SW'(1) : ((s_rd != '0) ? s_rd - SW'(1) : s_rd);
      end
      FALL: begin
        s_we = (s_rd != '0);
        s_wd = s_rd - SW'(1);
      end
      FIX: begin
        s_we = ($signed({1'b0, s_rd}) + diff_q >= 0);
        s_wd = SW'($signed({1'b0, s_rd}) + diff_q);
      end
      APPLY_RD: raddr = best_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LOAD; n_q <= '0; sum_q <= '0; idx_q <= '0; obusy_q <= 1'b0;
      diff_q <= '0; k_q <= '0; used_q <= '0; any_q <= 1'b0;
      bit_q <= '0; rem_q <= '0; quo_q <= '0; num_q <= '0; best_q <= '0;
      bestr_q <= '0; oshare_q <= '0; oidx_q <= '0; olast_q <= 1'b0;
    end else begin
      // result register: filled on emit, freed when the sink takes the word
      if (state_q == EMIT) obusy_q <= 1'b1;
      else if (obusy_q && out_o.ready) obusy_q <= 1'b0;
      unique case (state_q)
        LOAD: if (acc) begin
          if (n_q < NW'(MaxEntries)) begin
            n_q <= n_q + NW'(1);
            sum_q <= sum_q + SumW'(cin);
          end
          if (in_i.is_last) begin
            idx_q <= '0;
            diff_q <= DW'(TargetTotal);
            state_q <= DRD;
          end
        end
        DRD: state_q <= DWAIT;
        DWAIT: begin
          num_q <= NumW'(c_rd) * NumW'(TargetTotal);
          rem_q <= '0; quo_q <= '0; bit_q <= BW'(NumW + 1);
          state_q <= (sum_q == '0) ? DWR : DIV;
        end
        DIV: begin
          if (trial >= twos) begin
            rem_q <= trial - twos;
            quo_q <= {quo_q[QW-2:0], 1'b1};
          end else begin
            rem_q <= trial;
            quo_q <= {quo_q[QW-2:0], 1'b0};
          end
          if (bit_q == '0) state_q <= DWR;
          else bit_q <= bit_q - BW'(1);
        end
        DWR: begin
          diff_q <= diff_q - DW'(s_wd);
          if (last_idx) begin
            state_q <= SUMC;
          end else begin
            idx_q <= idx_q + AW'(1);
            state_q <= DRD;
          end
        end
        SUMC: begin
          k_q <= '0; used_q <= '0; idx_q <= '0; any_q <= 1'b0;
          if (sum_q == '0 || diff_q == 0) state_q <= EMIT_RD;
          else state_q <= SCAN_RD;
        end
        SCAN_RD: state_q <= SCAN;
        SCAN: begin
          if (!used_q[idx_q] && better) begin
            best_q <= idx_q; bestr_q <= rcur; any_q <= 1'b1;
          end
          if (last_idx) state_q <= APPLY_RD;
          else begin
            idx_q <= idx_q + AW'(1);
            state_q <= SCAN_RD;
          end
        end
        APPLY_RD: state_q <= APPLY;
        APPLY: begin
          logic [NW:0] kn;
          logic wrap;
          kn = k_q + (NW+1)'(1);
          wrap = (diff_q > 0) && (kn == (NW+1)'(n_q));
          if (diff_q > 0 || s_rd != '0) diff_q <= (diff_q > 0) ? diff_q - DW'(1) : diff_q + DW'(1);
          // a full pass of a shortfall starts the order over
          if (wrap) begin
            used_q <= '0; k_q <= '0;
          end else begin
            used_q[best_q] <= 1'b1; k_q <= kn;
          end
          idx_q <= '0; any_q <= 1'b0;
          if (diff_q > 0) begin
            if (diff_q == DW'(1)) state_q <= FIX_RD;
            else state_q <= SCAN_RD;
          end else begin
            if ((s_rd != '0 && diff_q == -DW'(1))) state_q <= FIX_RD;
            else if (kn == (NW+1)'(n_q)) state_q <= FALL_RD;
            else state_q <= SCAN_RD;
          end
        end
        FALL_RD: state_q <= FALL;
        FALL: begin
          if (s_rd != '0) diff_q <= diff_q + DW'(1);
          if ((s_rd != '0 && diff_q == -DW'(1)) || last_idx) begin
            idx_q <= '0; state_q <= FIX_RD;
          end else begin
            idx_q <= idx_q + AW'(1); state_q <= FALL_RD;
          end
        end
        FIX_RD: begin
          if (diff_q == 0) begin
            idx_q <= '0; state_q <= EMIT_RD;
          end else state_q <= FIX;
        end
        FIX: begin
          if (s_we || last_idx) begin
            diff_q <= '0; idx_q <= '0; state_q <= EMIT_RD;
          end else begin
            idx_q <= idx_q + AW'(1); state_q <= FIX_RD;
          end
        end
        EMIT_RD: if (!obusy_q || out_o.ready) state_q <= EMIT;
        EMIT: begin
          oshare_q <= s_rd[ShareWd-1:0];
          oidx_q <= lrn_pkg::IdxW'(idx_q);
          olast_q <= last_idx;
          if (last_idx) begin
            n_q <= '0; sum_q <= '0; idx_q <= '0; state_q <= LOAD;
          end else begin
            idx_q <= idx_q + AW'(1); state_q <= EMIT_RD;
          end
        end
        default: state_q <= LOAD;
      endcase
    end
  end

  // the result register holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    obusy_q && !out_o.ready |=> obusy_q && $stable(oshare_q)) else $error("word lost");
  // no input taken during a run
  a_noin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != LOAD |-> !in_i.ready) else $error("input during run");
  // the count never exceeds the vector size
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MaxEntries)) else $error("count overflow");
endmodule
`default_nettype wire
